// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, off while reset is low.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check on the rising clock edge, active during reset too.
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/lrupr_pkg.sv =====
`default_nettype none

package lrupr_pkg;

  localparam int MaxFrames   = 16;
  localparam int PageBits    = 20;
  localparam int ProcessBits = 16;
  localparam int CountBits   = 32;
  localparam int CfgW        = 5;
  localparam int CfgReset    = 16;

  localparam int AddrW = (MaxFrames > 1) ? $clog2(MaxFrames) : 1;
  localparam int CntW  = $clog2(MaxFrames + 1);

  localparam int InFieldW   = ProcessBits + PageBits;
  localparam int InDataW    = ((InFieldW + 7) / 8) * 8;
  localparam int OutFieldW  = 1 + CountBits + 1 + ProcessBits + PageBits;
  localparam int OutDataW   = ((OutFieldW + 7) / 8) * 8;

  typedef logic [AddrW-1:0]     addr_t;
  typedef logic [CntW-1:0]      cnt_t;
  typedef logic [CfgW-1:0]      cfg_t;
  typedef logic [CountBits-1:0] count_t;

  typedef struct packed {
    logic [PageBits-1:0]    page;
    logic [ProcessBits-1:0] pid;
  } entry_t;

  typedef struct packed {
    logic [PageBits-1:0]    ev_page;
    logic [ProcessBits-1:0] ev_process;
    logic                   evicted;
    count_t                 fault_total;
    logic                   hit;
  } res_t;

  typedef logic [OutDataW-1:0] out_data_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_MISS,
    S_COPY_RD,
    S_COPY_WR,
    S_WRITE_NEW
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/core/lrupr_ctrl.sv =====
`default_nettype none

`include "assert_macros.svh"

module lrupr_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire lrupr_pkg::cfg_t      frames_i,
  input  wire logic                 req_valid_i,
  output logic                      req_ready_o,
  input  wire lrupr_pkg::entry_t    req_entry_i,
  output logic                      res_valid_o,
  input  wire logic                 res_ready_i,
  output lrupr_pkg::res_t           res_o
);

  lrupr_pkg::entry_t mem [lrupr_pkg::MaxFrames];

  lrupr_pkg::state_e state_q, state_d;
  lrupr_pkg::cnt_t   idx_q, idx_d;
  lrupr_pkg::cnt_t   occ_q, occ_d;
  lrupr_pkg::cnt_t   drop_q, drop_d;
  lrupr_pkg::count_t fault_q, fault_d;
  lrupr_pkg::entry_t key_q, key_d;
  lrupr_pkg::entry_t ev_ent_q, ev_ent_d;
  logic              hit_q, hit_d;
  logic              ev_q, ev_d;

  logic              mem_we;
  lrupr_pkg::addr_t  wr_addr;
  lrupr_pkg::entry_t wr_data;
  logic              rd_en;
  lrupr_pkg::addr_t  rd_addr;
  lrupr_pkg::entry_t rd_data_q;

  lrupr_pkg::cnt_t          lim;
  lrupr_pkg::cnt_t          miss_drop;
  logic [lrupr_pkg::CntW:0] idx_plus_drop;
  logic [lrupr_pkg::CntW:0] idx_plus_one;
  lrupr_pkg::cnt_t          base;

  always_comb begin
    if (frames_i == '0) begin
      lim = lrupr_pkg::cnt_t'(1);
    end else if (32'(frames_i) > lrupr_pkg::MaxFrames) begin
      lim = lrupr_pkg::cnt_t'(lrupr_pkg::MaxFrames);
    end else begin
      lim = lrupr_pkg::cnt_t'(frames_i);
    end
  end

  assign miss_drop     = (occ_q >= lim) ? lrupr_pkg::cnt_t'(occ_q - lim + 1'b1) : '0;
  assign idx_plus_drop = {1'b0, idx_q} + {1'b0, drop_q};
  assign idx_plus_one  = {1'b0, idx_q} + 1'b1;
  assign base          = occ_q - drop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lrupr_pkg::S_IDLE;
      occ_q   <= '0;
      fault_q <= '0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      fault_q <= fault_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    drop_q   <= drop_d;
    key_q    <= key_d;
    ev_ent_q <= ev_ent_d;
    hit_q    <= hit_d;
    ev_q     <= ev_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    occ_d       = occ_q;
    drop_d      = drop_q;
    fault_d     = fault_q;
    key_d       = key_q;
    ev_ent_d    = ev_ent_q;
    hit_d       = hit_q;
    ev_d        = ev_q;
    mem_we      = 1'b0;
    wr_addr     = lrupr_pkg::addr_t'(idx_q);
    wr_data     = rd_data_q;
    rd_en       = 1'b0;
    rd_addr     = lrupr_pkg::addr_t'(idx_q);
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      lrupr_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          key_d    = req_entry_i;
          idx_d    = '0;
          hit_d    = 1'b0;
          ev_d     = 1'b0;
          ev_ent_d = '0;
          state_d  = (occ_q == '0) ? lrupr_pkg::S_MISS : lrupr_pkg::S_SCAN_RD;
        end
      end
      lrupr_pkg::S_SCAN_RD: begin
        rd_en   = 1'b1;
        state_d = lrupr_pkg::S_SCAN_CMP;
      end
      lrupr_pkg::S_SCAN_CMP: begin
        if (idx_q == '0) begin
          ev_ent_d = rd_data_q;
        end
        if (rd_data_q == key_q) begin
          hit_d    = 1'b1;
          drop_d   = lrupr_pkg::cnt_t'(1);
          ev_ent_d = '0;
          state_d  = lrupr_pkg::S_COPY_RD;
        end else if (idx_plus_one == {1'b0, occ_q}) begin
          state_d = lrupr_pkg::S_MISS;
        end else begin
          idx_d   = lrupr_pkg::cnt_t'(idx_plus_one);
          state_d = lrupr_pkg::S_SCAN_RD;
        end
      end
      lrupr_pkg::S_MISS: begin
        if (fault_q != '1) begin
          fault_d = fault_q + 1'b1;
        end
        drop_d = miss_drop;
        ev_d   = (miss_drop != '0);
        if (miss_drop == '0) begin
          ev_ent_d = '0;
          idx_d    = occ_q;
        end else begin
          idx_d = '0;
        end
        state_d = lrupr_pkg::S_COPY_RD;
      end
      lrupr_pkg::S_COPY_RD: begin
        if (idx_plus_drop < {1'b0, occ_q}) begin
          rd_en   = 1'b1;
          rd_addr = lrupr_pkg::addr_t'(idx_plus_drop);
          state_d = lrupr_pkg::S_COPY_WR;
        end else begin
          state_d = lrupr_pkg::S_WRITE_NEW;
        end
      end
      lrupr_pkg::S_COPY_WR: begin
        mem_we  = 1'b1;
        wr_addr = lrupr_pkg::addr_t'(idx_q);
        wr_data = rd_data_q;
        idx_d   = lrupr_pkg::cnt_t'(idx_plus_one);
        state_d = lrupr_pkg::S_COPY_RD;
      end
      lrupr_pkg::S_WRITE_NEW: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          mem_we  = 1'b1;
          wr_addr = lrupr_pkg::addr_t'(base);
          wr_data = key_q;
          occ_d   = base + 1'b1;
          state_d = lrupr_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = lrupr_pkg::S_IDLE;
      end
    endcase
  end

  assign res_o.hit         = hit_q;
  assign res_o.fault_total = fault_q;
  assign res_o.evicted     = ev_q;
  assign res_o.ev_process  = ev_ent_q.pid;
  assign res_o.ev_page     = ev_ent_q.page;

  `ASSERT_CLK_RST(a_occ_bound, clk_i, rst_ni, occ_q <= lrupr_pkg::MaxFrames, "occupancy overflow")
  `ASSERT_CLK_RST(a_fault_mono, clk_i, rst_ni, fault_q >= $past(fault_q), "fault count went down")
  `ASSERT_CLK_RST(a_hit_no_evict, clk_i, rst_ni, res_valid_o |-> !(res_o.hit && res_o.evicted), "hit reported an eviction")
  `ASSERT_CLK(a_reset_idle, clk_i, !rst_ni |-> (state_q == lrupr_pkg::S_IDLE && !res_valid_o), "busy during reset")

endmodule

`default_nettype wire

// ===== rtl/core/lru_page_replacement.sv =====
// LRU page replacement table.
// Slave stream: one reference per transaction, tdata carries process id and
// page number. Master stream: one result per reference with hit, the running
// saturating fault count and the evicted entry (zeros when nothing left).
// cfg_we_i/cfg_wdata_i set the frame limit (0 acts as 1, above 16 acts as 16);
// write it only while no reference is in flight.
// The entries sit in one 16-deep memory in recency order. A lookup
// reads and then compares one slot at a time (S_SCAN_RD, S_SCAN_CMP); a hit or
// eviction closes the gap by copying each later entry down (S_COPY_RD, then
// S_COPY_WR); the new entry is then written at the most-recent end.
// s_axis_tready_o is high only between references.
// Reset empties the table, clears the fault count and sets the limit to 16.
// The result waits in an output register; the next reference is accepted and
// processed while it waits, and only its final write-back holds off until the
// receiver takes the earlier result.
`default_nettype none

module lru_page_replacement (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [lrupr_pkg::CfgW-1:0]        cfg_wdata_i,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // process_id, page_number
  input  wire logic [lrupr_pkg::InDataW-1:0]     s_axis_tdata_i,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // hit, fault_total, evicted, evicted_process, evicted_page
  output logic [lrupr_pkg::OutDataW-1:0]         m_axis_tdata_o
);

  lrupr_pkg::cfg_t      frames_q;
  logic                 out_valid_q;
  lrupr_pkg::out_data_t out_data_q;

  lrupr_pkg::entry_t req_entry;
  logic              res_valid;
  logic              res_ready;
  lrupr_pkg::res_t   res;

  assign req_entry.pid  = s_axis_tdata_i[lrupr_pkg::ProcessBits-1:0];
  assign req_entry.page = s_axis_tdata_i[lrupr_pkg::ProcessBits +: lrupr_pkg::PageBits];

  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= lrupr_pkg::cfg_t'(lrupr_pkg::CfgReset);
    end else if (cfg_we_i) begin
      frames_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= lrupr_pkg::out_data_t'(res);
    end
  end

  lrupr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frames_i    (frames_q),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .req_entry_i (req_entry),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

`default_nettype wire

// ===== tb/sv/lru_replacement_checker.sv =====
`default_nettype none

module lru_replacement_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [lrupr_pkg::CfgW-1:0]    cfg_wdata_i,
  input  wire logic                          s_axis_tvalid_i,
  input  wire logic                          s_axis_tready_o,
  input  wire logic [lrupr_pkg::InDataW-1:0] s_axis_tdata_i,
  input  wire logic                          m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  input  wire logic [lrupr_pkg::OutDataW-1:0] m_axis_tdata_o,
  output int                                 outstanding,
  output int                                 mismatches,
  output int                                 hit_count,
  output int                                 evict_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PendDepth = 16;

  logic [lrupr_pkg::ProcessBits-1:0] shadow_pid  [lrupr_pkg::MaxFrames];
  logic [lrupr_pkg::PageBits-1:0]    shadow_page [lrupr_pkg::MaxFrames];
  int                                shadow_occupied;
  lrupr_pkg::count_t                 shadow_faults;
  lrupr_pkg::cfg_t                   shadow_limit;

  lrupr_pkg::res_t pending [PendDepth];
  int              pend_rd;
  int              pend_wr;
  int              pend_count;
  lrupr_pkg::res_t got;
  lrupr_pkg::res_t want;

  // Close the gap at pos, moving later entries toward the oldest end.
  function automatic void drop_entry(input int pos);
    int k;
    for (k = pos; k + 1 < shadow_occupied; k++) begin
      shadow_pid[k]  = shadow_pid[k+1];
      shadow_page[k] = shadow_page[k+1];
    end
    if (shadow_occupied > 0) shadow_occupied--;
  endfunction

  function automatic lrupr_pkg::res_t lru_access(
      input logic [lrupr_pkg::ProcessBits-1:0] pid,
      input logic [lrupr_pkg::PageBits-1:0]    page);
    int              lim;
    int              pos;
    int              k;
    bit              found;
    lrupr_pkg::res_t r;
    lim   = int'(shadow_limit);
    found = 1'b0;
    pos   = 0;
    r     = '0;
    if (lim < 1) lim = 1;
    if (lim > lrupr_pkg::MaxFrames) lim = lrupr_pkg::MaxFrames;
    for (k = 0; k < shadow_occupied; k++) begin
      if (!found && shadow_pid[k] == pid && shadow_page[k] == page) begin
        found = 1'b1;
        pos   = k;
      end
    end
    if (found) begin
      drop_entry(pos);
    end else begin
      if (shadow_faults != '1) shadow_faults++;
      while (shadow_occupied >= lim) begin
        if (!r.evicted) begin
          r.evicted    = 1'b1;
          r.ev_process = shadow_pid[0];
          r.ev_page    = shadow_page[0];
        end
        drop_entry(0);
      end
    end
    if (shadow_occupied < lrupr_pkg::MaxFrames) begin
      shadow_pid[shadow_occupied]  = pid;
      shadow_page[shadow_occupied] = page;
      shadow_occupied++;
    end
    r.hit         = found;
    r.fault_total = shadow_faults;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_occupied = 0;
      shadow_faults   = '0;
      shadow_limit    = lrupr_pkg::cfg_t'(lrupr_pkg::CfgReset);
      pend_rd         = 0;
      pend_wr         = 0;
      pend_count      = 0;
      outstanding     = 0;
      mismatches      = 0;
      hit_count       = 0;
      evict_count     = 0;
    end else begin
      if (cfg_we_i) shadow_limit = cfg_wdata_i;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = lrupr_pkg::res_t'(m_axis_tdata_o[lrupr_pkg::OutFieldW-1:0]);
        if (pend_count == 0) begin
          $error("result: none outstanding, got tdata %0h", m_axis_tdata_o);
          mismatches++;
        end else begin
          want    = pending[pend_rd];
          pend_rd = (pend_rd + 1) % PendDepth;
          pend_count--;
          check_field("hit", 32'(want.hit), 32'(got.hit));
          check_field("fault_total", want.fault_total, got.fault_total);
          check_field("evicted", 32'(want.evicted), 32'(got.evicted));
          check_field("evicted_process", 32'(want.ev_process), 32'(got.ev_process));
          check_field("evicted_page", 32'(want.ev_page), 32'(got.ev_page));
          if (want.hit) hit_count++;
          if (want.evicted) evict_count++;
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        if (pend_count == PendDepth) begin
          $error("reference: too many outstanding, tdata %0h", s_axis_tdata_i);
          mismatches++;
        end else begin
          pending[pend_wr] = lru_access(s_axis_tdata_i[lrupr_pkg::ProcessBits-1:0],
              s_axis_tdata_i[lrupr_pkg::ProcessBits +: lrupr_pkg::PageBits]);
          pend_wr = (pend_wr + 1) % PendDepth;
          pend_count++;
        end
      end
      outstanding = pend_count;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 80;
  localparam int PhaseItems  = 66;
  localparam int NumPhases   = 8;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               cfg_we_i;
  logic [lrupr_pkg::CfgW-1:0]         cfg_wdata_i;
  logic                               s_axis_tvalid_i;
  logic                               s_axis_tready_o;
  logic [lrupr_pkg::InDataW-1:0]      s_axis_tdata_i;
  logic                               m_axis_tvalid_o;
  logic                               m_axis_tready_i;
  logic [lrupr_pkg::OutDataW-1:0]     m_axis_tdata_o;

  int outstanding;
  int mismatches;
  int hit_count;
  int evict_count;
  int cycles;
  int ref_count;
  int limit_writes;
  bit steady;

  logic [lrupr_pkg::ProcessBits-1:0] pid_pool  [4];
  logic [lrupr_pkg::PageBits-1:0]    page_pool [6];
  lrupr_pkg::cfg_t                   phase_limit [NumPhases];
  int                                pid_span;
  int                                page_span;

  lru_page_replacement DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  lru_replacement_checker u_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .outstanding     (outstanding),
    .mismatches      (mismatches),
    .hit_count       (hit_count),
    .evict_count     (evict_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready_i <= steady || ($urandom_range(0, 99) >= 10);
  end

  task automatic send_ref(input logic [lrupr_pkg::ProcessBits-1:0] pid,
                          input logic [lrupr_pkg::PageBits-1:0] page);
    @(negedge clk_i);
    while (!steady && $urandom_range(0, 99) < 10) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(lrupr_pkg::InDataW - lrupr_pkg::InFieldW){1'b0}}, page, pid};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    ref_count++;
  endtask

  // Drop valid and hold until every result has been taken.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  task automatic write_limit(input lrupr_pkg::cfg_t value);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    limit_writes++;
  endtask

  task automatic send_random_ref();
    if ($urandom_range(0, 99) < 15) begin
      send_ref(lrupr_pkg::ProcessBits'($urandom), lrupr_pkg::PageBits'($urandom));
    end else begin
      send_ref(pid_pool[$urandom_range(0, pid_span - 1)],
               page_pool[$urandom_range(0, page_span - 1)]);
    end
  endtask

  initial begin
    int k;
    int phase;
    rst_ni          = 1'b1;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    steady          = 1'b0;
    ref_count       = 0;
    limit_writes    = 0;
    phase_limit     = '{5'd0, 5'd1, 5'd31, 5'd3, 5'd16, 5'd10, 5'd17,
                        lrupr_pkg::cfg_t'($urandom_range(0, 31))};
    #1;
    rst_ni = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // fill the table at the reset limit, then hit and evict
    send_ref('0, '0);
    send_ref('1, '1);
    send_ref('0, '1);
    send_ref('1, '0);
    for (k = 0; k < 12; k++) send_ref(16'h1 << k, 20'h10 << k);
    send_ref('0, '0);
    send_ref('1, '1);
    send_ref(16'h1234, 20'h56789);
    drain();

    // limit below occupancy: hit on a resident entry, then a multi-drop miss
    write_limit(5'd2);
    send_ref('1, '0);
    send_ref(16'habcd, 20'h09876);
    drain();

    write_limit(5'd0);
    send_ref(16'h5555, 20'haaaaa);
    send_ref(16'haaaa, 20'h55555);
    drain();

    for (phase = 0; phase < NumPhases; phase++) begin
      write_limit(phase_limit[phase]);
      steady = (phase == 4);
      foreach (pid_pool[i]) pid_pool[i] = lrupr_pkg::ProcessBits'($urandom);
      foreach (page_pool[i]) page_pool[i] = lrupr_pkg::PageBits'($urandom);
      if ($urandom_range(0, 1)) pid_pool[0] = '1;
      if ($urandom_range(0, 1)) page_pool[0] = '0;
      pid_span  = $urandom_range(1, 4);
      page_span = $urandom_range(1, 6);
      repeat (PhaseItems) send_random_ref();
      drain();
    end
    steady = 1'b0;

    repeat (DrainCycles) @(negedge clk_i);
    $display("Covered %0d references across %0d frame-limit writes (0, 1, 2, 16 and above).",
             ref_count, limit_writes);
    $display("Observed %0d hits and %0d evictions.", hit_count, evict_count);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
